### rtl/pfc_pkg.sv
// Shared types, constants and letter helpers for the Playfair cipher block.
// Used by pfc_tables, pfc_rule and playfair_cipher_top; depends on nothing else.
package pfc_pkg;

    localparam int SqCells = 25;
    localparam int Letters = 26;

    typedef logic [4:0] t_code;
    typedef logic [4:0] t_pos;

    localparam t_code CodeI = 5'd8;
    localparam t_code CodeJ = 5'd9;
    localparam t_code CodeX = 5'd23;

    localparam logic [7:0] ChLowA = 8'h61;
    localparam logic [7:0] ChLowZ = 8'h7A;
    localparam logic [7:0] ChUpA  = 8'h41;
    localparam logic [7:0] ChUpZ  = 8'h5A;
    localparam logic [6:0] AsciiA = 7'h41;

    typedef struct packed {
        logic  ok;
        t_code code;
    } t_norm;

    // One write into both tables: square[pos] = code and place[code] = pos.
    typedef struct packed {
        logic  en;
        t_pos  pos;
        t_code code;
    } t_tbl_wr;

    typedef struct packed {
        logic  sq_en;
        t_pos  sq_addr;
        logic  pl_en;
        t_code pl_addr;
    } t_tbl_rd;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_PLACE  = 10'b00_0000_0010,
        S_FILL   = 10'b00_0000_0100,
        S_DECIDE = 10'b00_0000_1000,
        S_PA     = 10'b00_0001_0000,
        S_PB     = 10'b00_0010_0000,
        S_Q1     = 10'b00_0100_0000,
        S_Q2     = 10'b00_1000_0000,
        S_OUT1   = 10'b01_0000_0000,
        S_OUT2   = 10'b10_0000_0000
    } t_state;

    // Uppercases, rejects non-letters and folds J onto I.
    function automatic t_norm norm_letter(input logic [7:0] ch);
        logic [7:0] up;
        logic [7:0] diff;
        t_norm      res;
        up       = (ch >= ChLowA && ch <= ChLowZ) ? ch - 8'd32 : ch;
        diff     = up - ChUpA;
        res.ok   = (up >= ChUpA && up <= ChUpZ);
        res.code = diff[4:0];
        if (res.code == CodeJ) begin
            res.code = CodeI;
        end
        return res;
    endfunction

    // Letter at a position of the plain square (alphabet without J).
    function automatic t_code plain_letter(input t_pos pos);
        return (pos <= CodeI) ? pos : pos + 5'd1;
    endfunction

    // Position of a letter in the plain square; J lands on the place of I.
    function automatic t_pos plain_place(input t_code code);
        return (code <= CodeI) ? code : code - 5'd1;
    endfunction

    function automatic logic [6:0] letter_ascii(input t_code code);
        return AsciiA + {2'b00, code};
    endfunction

endpackage

### rtl/pfc_tables.sv
// Square and letter-place memories with registered reads.
// Depends on pfc_pkg. Until the first key completes, reads return the plain square.
module pfc_tables (
    input  logic             i_clk,
    input  logic             i_custom,
    input  pfc_pkg::t_tbl_wr i_wr,
    input  pfc_pkg::t_tbl_rd i_rd,
    output pfc_pkg::t_code   o_sq_code,
    output pfc_pkg::t_pos    o_pl_pos
);
    import pfc_pkg::*;

    t_code mem_sq [SqCells];
    t_pos  mem_pl [Letters];

    t_code r_sq_mem;
    t_code r_sq_plain;
    t_pos  r_pl_mem;
    t_pos  r_pl_plain;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem_sq[i_wr.pos]  <= i_wr.code;
            mem_pl[i_wr.code] <= i_wr.pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.sq_en) begin
            r_sq_mem   <= mem_sq[i_rd.sq_addr];
            r_sq_plain <= plain_letter(i_rd.sq_addr);
        end
        if (i_rd.pl_en) begin
            r_pl_mem   <= mem_pl[i_rd.pl_addr];
            r_pl_plain <= plain_place(i_rd.pl_addr);
        end
    end

    assign o_sq_code = i_custom ? r_sq_mem : r_sq_plain;
    assign o_pl_pos  = i_custom ? r_pl_mem : r_pl_plain;

endmodule

### rtl/pfc_rule.sv
// Playfair pair rule for one letter: row shift, column shift or rectangle swap.
// Depends on pfc_pkg. Shared by both letters of a pair, one per cycle.
module pfc_rule (
    input  pfc_pkg::t_pos i_own,
    input  pfc_pkg::t_pos i_other,
    input  logic          i_decrypt,
    output pfc_pkg::t_pos o_pos
);
    import pfc_pkg::*;

    function automatic logic [2:0] row_of(input t_pos pos);
        logic [2:0] r;
        if (pos >= 5'd20) begin
            r = 3'd4;
        end else if (pos >= 5'd15) begin
            r = 3'd3;
        end else if (pos >= 5'd10) begin
            r = 3'd2;
        end else if (pos >= 5'd5) begin
            r = 3'd1;
        end else begin
            r = 3'd0;
        end
        return r;
    endfunction

    function automatic logic [4:0] times5(input logic [2:0] v);
        return {v, 2'b00} + {2'b00, v};
    endfunction

    function automatic logic [2:0] wrap5(input logic [2:0] v, input logic [2:0] sh);
        logic [3:0] s;
        logic [3:0] w;
        s = {1'b0, v} + {1'b0, sh};
        w = (s >= 4'd5) ? s - 4'd5 : s;
        return w[2:0];
    endfunction

    logic [2:0] own_r;
    logic [2:0] own_c;
    logic [2:0] oth_r;
    logic [2:0] oth_c;
    logic [2:0] sh;
    logic [4:0] own_c5;
    logic [4:0] oth_c5;

    always_comb begin
        own_r  = row_of(i_own);
        oth_r  = row_of(i_other);
        own_c5 = i_own - times5(own_r);
        oth_c5 = i_other - times5(oth_r);
        own_c  = own_c5[2:0];
        oth_c  = oth_c5[2:0];
        sh     = i_decrypt ? 3'd4 : 3'd1;
        if (own_r == oth_r) begin
            o_pos = times5(own_r) + {2'b00, wrap5(own_c, sh)};
        end else if (own_c == oth_c) begin
            o_pos = times5(wrap5(own_r, sh)) + {2'b00, own_c};
        end else begin
            o_pos = times5(own_r) + {2'b00, oth_c};
        end
    end

endmodule

### rtl/playfair_cipher_top.sv
// Playfair cipher top level: handshake, sequencer and key/text state.
// Depends on pfc_pkg, pfc_tables and pfc_rule.
//
// Usage: input beats (i_op, i_in_char, i_in_last) arrive on a valid/ready
// channel; o_in_ready is high only while the block is idle. A key beat
// (op 0) is placed in S_PLACE; one with in_last also completes the
// square with the unused letters, one plain-alphabet letter per cycle.
// A text beat (op 1) that arrives with a key still open runs that same
// fill first. A text beat that closes a pair passes S_DECIDE, S_PA, S_PB,
// S_Q1 and S_Q2 before its first output beat; the second follows once the
// first is taken; ready returns in the cycle after the second is taken.
// The pair is worked through one letter at a time on a single rule unit and
// single read ports of the square and letter-place memories.
// When the receiver holds i_out_ready low, the output beat holds and the
// block stays busy. Reset returns the plain square, clears the held letter
// and selects encryption. i_cfg_we writes the decrypt bit at any idle edge.
module playfair_cipher_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_op,
    input  logic [7:0] i_in_char,
    input  logic       i_in_last,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [6:0] o_out_char,
    output logic       o_out_last
);
    import pfc_pkg::*;

    t_state              r_state,    n_state;
    logic [Letters-1:0]  r_seen,     n_seen;
    logic [4:0]          r_fill,     n_fill;
    logic                r_key_open, n_key_open;
    logic                r_custom,   n_custom;
    logic [4:0]          r_idx,      n_idx;
    logic                r_held_ok,  n_held_ok;
    logic                r_decrypt,  n_decrypt;
    logic                r_op,       n_op;
    t_code               r_code,     n_code;
    logic                r_code_ok,  n_code_ok;
    logic                r_last,     n_last;
    t_code               r_held,     n_held;
    t_code               r_a,        n_a;
    t_code               r_b,        n_b;
    logic                r_plast,    n_plast;
    t_pos                r_pa,       n_pa;
    t_pos                r_pb,       n_pb;
    t_code               r_l1,       n_l1;

    t_tbl_wr wr;
    t_tbl_rd rd;
    t_code   sq_code;
    t_pos    pl_pos;
    t_pos    rule_own;
    t_pos    rule_other;
    t_pos    rule_pos;
    t_code   wr_code;
    t_norm   nrm;

    pfc_tables u_tables (
        .i_clk     (i_clk),
        .i_custom  (r_custom),
        .i_wr      (wr),
        .i_rd      (rd),
        .o_sq_code (sq_code),
        .o_pl_pos  (pl_pos)
    );

    pfc_rule u_rule (
        .i_own     (rule_own),
        .i_other   (rule_other),
        .i_decrypt (r_decrypt),
        .o_pos     (rule_pos)
    );

    // The first letter's rule needs the second place straight off the read port.
    assign rule_own   = (r_state == S_Q1) ? r_pa   : r_pb;
    assign rule_other = (r_state == S_Q1) ? pl_pos : r_pa;

    always_comb begin
        rd.pl_en   = (r_state == S_PA) || (r_state == S_PB);
        rd.pl_addr = (r_state == S_PA) ? r_a : r_b;
        rd.sq_en   = (r_state == S_Q1) || (r_state == S_Q2);
        rd.sq_addr = rule_pos;
    end

    always_comb begin
        wr_code = (r_state == S_FILL) ? plain_letter(r_idx) : r_code;
        wr.en   = ((r_state == S_FILL) || ((r_state == S_PLACE) && r_code_ok))
                  && !r_seen[wr_code] && (r_fill < 5'(SqCells));
        wr.pos  = r_fill;
        wr.code = wr_code;
    end

    assign nrm = norm_letter(i_in_char);

    always_comb begin
        n_state    = r_state;
        n_seen     = r_seen;
        n_fill     = r_fill;
        n_key_open = r_key_open;
        n_custom   = r_custom;
        n_idx      = r_idx;
        n_held_ok  = r_held_ok;
        n_decrypt  = i_cfg_we ? i_cfg_data : r_decrypt;
        n_op       = r_op;
        n_code     = r_code;
        n_code_ok  = r_code_ok;
        n_last     = r_last;
        n_held     = r_held;
        n_a        = r_a;
        n_b        = r_b;
        n_plast    = r_plast;
        n_pa       = r_pa;
        n_pb       = r_pb;
        n_l1       = r_l1;

        if (wr.en) begin
            n_seen[wr_code] = 1'b1;
            n_fill          = r_fill + 5'd1;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op      = i_op;
                    n_code    = nrm.code;
                    n_code_ok = nrm.ok;
                    n_last    = i_in_last;
                    if (!i_op) begin
                        if (!r_key_open) begin
                            n_seen     = '0;
                            n_fill     = '0;
                            n_key_open = 1'b1;
                        end
                        n_state = S_PLACE;
                    end else if (r_key_open) begin
                        n_idx   = '0;
                        n_state = S_FILL;
                    end else begin
                        n_state = S_DECIDE;
                    end
                end
            end
            S_PLACE: begin
                if (r_last) begin
                    n_idx   = '0;
                    n_state = S_FILL;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FILL: begin
                if (r_idx == 5'(SqCells - 1)) begin
                    n_key_open = 1'b0;
                    n_custom   = 1'b1;
                    n_state    = r_op ? S_DECIDE : S_IDLE;
                end else begin
                    n_idx = r_idx + 5'd1;
                end
            end
            S_DECIDE: begin
                n_state = S_PA;
                n_plast = r_last;
                if (!r_code_ok) begin
                    if (r_last && r_held_ok) begin
                        n_a       = r_held;
                        n_b       = CodeX;
                        n_plast   = 1'b1;
                        n_held_ok = 1'b0;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else if (r_held_ok) begin
                    n_a       = r_held;
                    n_b       = r_code;
                    n_held_ok = 1'b0;
                end else if (r_last) begin
                    n_a     = r_code;
                    n_b     = CodeX;
                    n_plast = 1'b1;
                end else begin
                    n_held    = r_code;
                    n_held_ok = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_PA: begin
                n_state = S_PB;
            end
            S_PB: begin
                n_pa    = pl_pos;
                n_state = S_Q1;
            end
            S_Q1: begin
                n_pb    = pl_pos;
                n_state = S_Q2;
            end
            S_Q2: begin
                n_l1    = sq_code;
                n_state = S_OUT1;
            end
            S_OUT1: begin
                if (i_out_ready) begin
                    n_state = S_OUT2;
                end
            end
            S_OUT2: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_seen     <= '0;
            r_fill     <= '0;
            r_key_open <= 1'b0;
            r_custom   <= 1'b0;
            r_idx      <= '0;
            r_held_ok  <= 1'b0;
            r_decrypt  <= 1'b0;
            r_held     <= '0;
        end else begin
            r_state    <= n_state;
            r_seen     <= n_seen;
            r_fill     <= n_fill;
            r_key_open <= n_key_open;
            r_custom   <= n_custom;
            r_idx      <= n_idx;
            r_held_ok  <= n_held_ok;
            r_decrypt  <= n_decrypt;
            r_held     <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_code    <= n_code;
        r_code_ok <= n_code_ok;
        r_last    <= n_last;
        r_a       <= n_a;
        r_b       <= n_b;
        r_plast   <= n_plast;
        r_pa      <= n_pa;
        r_pb      <= n_pb;
        r_l1      <= n_l1;
    end

    // The second letter stays in the square read register until it is taken.
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT1) || (r_state == S_OUT2);
    assign o_out_char  = (r_state == S_OUT1) ? letter_ascii(r_l1) : letter_ascii(sq_code);
    assign o_out_last  = (r_state == S_OUT2) && r_plast;

endmodule

### rtl/pfc_checker.sv
// Port-level checks for playfair_cipher_top, attached with a bind statement.
// Depends only on the top level's ports.
module pfc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [6:0] o_out_char,
    input logic       o_out_last
);

    // A stalled output beat holds its letter and flag.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_out_char) && $stable(o_out_last)))
        else $error("output beat changed while stalled");

    // The block works on one item at a time and never offers and takes together.
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while output pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready right after an accepted beat");

    a_letter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_char >= 7'd65 && o_out_char <= 7'd90))
        else $error("output is not an uppercase letter");

    // The last letter of a message closes the pair; nothing follows at once.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_last) |=> !o_out_valid)
        else $error("output beat right after the final letter");

endmodule

bind playfair_cipher_top pfc_checker u_pfc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_char  (o_out_char),
    .o_out_last  (o_out_last)
);

### sim/tb.sv
// Self-checking testbench for playfair_cipher_top: square build from key beats,
// text pairing and padding, and both cipher directions, checked by an in-bench predictor.
// Depends on pfc_pkg and the RTL under rtl/.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfc_pkg::*;

    localparam logic OpKey       = 1'b0;
    localparam logic OpText      = 1'b1;
    localparam logic ModeEncrypt = 1'b0;
    localparam logic ModeDecrypt = 1'b1;
    localparam int   SqSide      = 5;
    localparam int   SettleCycles = 40;
    localparam int   PhaseBeats  = 100;
    localparam int   MaxPrinted  = 100;

    typedef struct packed {
        logic       op;
        logic [7:0] ch;
        logic       last;
    } t_beat;

    typedef struct packed {
        logic [6:0] letter;
        logic       last;
    } t_cipher_out;

    logic       i_clk;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic       i_cfg_data  = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_ready;
    logic       i_op        = 1'b0;
    logic [7:0] i_in_char   = 8'h00;
    logic       i_in_last   = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [6:0] o_out_char;
    logic       o_out_last;

    // Predictor copy of the square, the key progress and the held letter.
    t_code sq_letter [SqCells];
    t_pos  sq_place [Letters];
    bit    key_seen [Letters];
    int    sq_fill;
    bit    key_active;
    t_code held_code;
    bit    held_ok;
    logic  mode_decrypt;

    t_cipher_out cipher_q[$];
    t_beat       send_q[$];
    t_beat       cur_beat;
    int          send_gap;
    int          recv_stall;
    int          idle_pct;
    int          err_count = 0;

    playfair_cipher_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_in_char   (i_in_char),
        .i_in_last   (i_in_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_char  (o_out_char),
        .o_out_last  (o_out_last)
    );

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Letter code of a raw character with J folded onto I, or -1 for a non-letter.
    function automatic int letter_code(input logic [7:0] ch);
        logic [7:0] up;
        int         code;
        up = ch;
        if (up inside {[ChLowA:ChLowZ]}) begin
            up = up ^ 8'h20;
        end
        if (!(up inside {[ChUpA:ChUpZ]})) begin
            return -1;
        end
        code = int'(up - ChUpA);
        if (t_code'(code) == CodeJ) begin
            code = int'(CodeI);
        end
        return code;
    endfunction

    function automatic void key_place(input t_code c);
        if (!key_seen[c] && sq_fill < SqCells) begin
            sq_letter[sq_fill] = c;
            sq_place[c] = t_pos'(sq_fill);
            key_seen[c] = 1'b1;
            sq_fill++;
        end
    endfunction

    // Closing a key appends every unused letter in alphabet order.
    function automatic void key_close();
        for (int c = 0; c < Letters; c++) begin
            if (t_code'(c) != CodeJ) begin
                key_place(t_code'(c));
            end
        end
        sq_place[CodeJ] = sq_place[CodeI];
        key_active = 1'b0;
    endfunction

    function automatic void pair_encode(input t_code a, input t_code b, input logic last);
        int          p1, p2, r1, c1, r2, c2, sh, q1, q2;
        t_cipher_out res;
        p1 = sq_place[a];
        p2 = sq_place[b];
        r1 = p1 / SqSide;
        c1 = p1 % SqSide;
        r2 = p2 / SqSide;
        c2 = p2 % SqSide;
        sh = (mode_decrypt == ModeDecrypt) ? SqSide - 1 : 1;
        if (r1 == r2) begin
            q1 = r1 * SqSide + (c1 + sh) % SqSide;
            q2 = r2 * SqSide + (c2 + sh) % SqSide;
        end else if (c1 == c2) begin
            q1 = ((r1 + sh) % SqSide) * SqSide + c1;
            q2 = ((r2 + sh) % SqSide) * SqSide + c2;
        end else begin
            q1 = r1 * SqSide + c2;
            q2 = r2 * SqSide + c1;
        end
        res.letter = AsciiA + sq_letter[q1];
        res.last   = 1'b0;
        cipher_q.push_back(res);
        res.letter = AsciiA + sq_letter[q2];
        res.last   = last;
        cipher_q.push_back(res);
    endfunction

    function automatic void cipher_step(input t_beat b);
        int code;
        code = letter_code(b.ch);
        if (b.op == OpKey) begin
            if (!key_active) begin
                foreach (key_seen[i]) begin
                    key_seen[i] = 1'b0;
                end
                sq_fill = 0;
                key_active = 1'b1;
            end
            if (code >= 0) begin
                key_place(t_code'(code));
            end
            if (b.last) begin
                key_close();
            end
        end else begin
            if (key_active) begin
                key_close();
            end
            if (code < 0) begin
                if (b.last && held_ok) begin
                    held_ok = 1'b0;
                    pair_encode(held_code, CodeX, 1'b1);
                end
            end else if (held_ok) begin
                held_ok = 1'b0;
                pair_encode(held_code, t_code'(code), b.last);
            end else if (b.last) begin
                pair_encode(t_code'(code), CodeX, 1'b1);
            end else begin
                held_code = t_code'(code);
                held_ok = 1'b1;
            end
        end
    endfunction

    function automatic void add_beat(input logic op, input logic [7:0] ch, input logic last);
        t_beat b;
        b.op   = op;
        b.ch   = ch;
        b.last = last;
        send_q.push_back(b);
    endfunction

    // Mostly letters of either case, with spaces and arbitrary bytes mixed in.
    function automatic logic [7:0] rand_char(input int noise_pct);
        logic [7:0] c;
        if ($urandom_range(0, 99) < noise_pct) begin
            c = ($urandom_range(0, 1) == 0) ? 8'h20 : 8'($urandom_range(0, 255));
        end else begin
            c = ChUpA + 8'($urandom_range(0, 25));
            if ($urandom_range(0, 1) == 1) begin
                c = c | 8'h20;
            end
        end
        return c;
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_count < MaxPrinted) begin
            $display("mismatch at %0t ns: %s", $time, msg);
        end
        err_count++;
    endtask

    task automatic set_mode(input logic m);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        mode_decrypt = m;
    endtask

    // Waits until every beat is taken and every expected letter has arrived,
    // then leaves room for a square fill that produces no output.
    task automatic wait_idle();
        @(negedge i_clk);
        while (send_q.size() != 0 || i_in_valid || cipher_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : drive_in
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                cipher_step(cur_beat);
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if ($urandom_range(0, 99) < idle_pct) begin
                    send_gap = $urandom_range(1, 18) - 1;
                    i_in_valid <= 1'b0;
                end else if (send_q.size() != 0) begin
                    cur_beat = send_q.pop_front();
                    i_op       <= cur_beat.op;
                    i_in_char  <= cur_beat.ch;
                    i_in_last  <= cur_beat.last;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watch_out
        t_cipher_out want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (cipher_q.size() == 0) begin
                    report_mismatch($sformatf("letter %02h with nothing expected", o_out_char));
                end else begin
                    want = cipher_q.pop_front();
                    if (o_out_char !== want.letter) begin
                        report_mismatch($sformatf("letter %02h, expected %02h",
                                                  o_out_char, want.letter));
                    end
                    if (o_out_last !== want.last) begin
                        report_mismatch($sformatf("last flag %b, expected %b",
                                                  o_out_last, want.last));
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                i_out_ready <= 1'b0;
            end else if ($urandom_range(0, 99) < idle_pct) begin
                recv_stall = $urandom_range(1, 18) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int   n, len, k, p;
        logic m;
        p = 0;
        for (int c = 0; c < Letters; c++) begin
            if (t_code'(c) != CodeJ) begin
                sq_letter[p] = t_code'(c);
                sq_place[c] = t_pos'(p);
                p++;
            end
        end
        sq_place[CodeJ] = sq_place[CodeI];
        foreach (key_seen[i]) begin
            key_seen[i] = 1'b0;
        end
        sq_fill = 0;
        key_active = 1'b0;
        held_code = '0;
        held_ok = 1'b0;
        mode_decrypt = ModeEncrypt;
        idle_pct = 15;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats on the plain square, then on a keyed one.
        add_beat(OpText, "h", 1'b0);
        add_beat(OpText, "E", 1'b0);
        add_beat(OpText, "l", 1'b0);
        add_beat(OpText, "L", 1'b0);      // equal letters stay together
        add_beat(OpText, "q", 1'b0);      // held across the key below
        add_beat(OpKey,  "P", 1'b0);
        add_beat(OpKey,  "l", 1'b0);
        add_beat(OpKey,  " ", 1'b0);
        add_beat(OpKey,  "A", 1'b0);
        add_beat(OpKey,  "y", 1'b0);
        add_beat(OpKey,  "j", 1'b0);
        add_beat(OpKey,  "I", 1'b0);      // duplicate after J folding
        add_beat(OpKey,  8'hFF, 1'b1);    // a non-letter still ends the key
        add_beat(OpText, "W", 1'b0);
        add_beat(OpText, "z", 1'b0);
        add_beat(OpText, 8'h00, 1'b0);
        add_beat(OpText, ".", 1'b1);      // held letter padded with X
        add_beat(OpText, " ", 1'b1);      // end with nothing held
        add_beat(OpText, "X", 1'b1);
        add_beat(OpKey,  "Z", 1'b0);
        add_beat(OpText, "a", 1'b0);      // text closes the open key first
        add_beat(OpText, "J", 1'b1);
        add_beat(OpText, 8'h40, 1'b0);
        add_beat(OpText, 8'h7B, 1'b0);
        add_beat(OpText, "g", 1'b0);      // held across the mode change
        wait_idle();

        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 3) begin
                m = logic'($urandom_range(0, 1));
            end else begin
                m = (phase % 2 == 0) ? ModeDecrypt : ModeEncrypt;
            end
            set_mode(m);
            if (phase == 5) begin
                idle_pct = 0;
            end else if (phase == 2) begin
                idle_pct = 2;
            end else begin
                idle_pct = $urandom_range(5, 25);
            end
            n = 0;
            while (n < PhaseBeats) begin
                k = $urandom_range(0, 9);
                if (k < 2) begin
                    len = $urandom_range(1, 12);
                    for (int i = 0; i < len; i++) begin
                        add_beat(OpKey, rand_char(10), i == len - 1);
                    end
                end else if (k < 8) begin
                    len = $urandom_range(1, 30);
                    for (int i = 0; i < len; i++) begin
                        add_beat(OpText, rand_char(15), i == len - 1);
                    end
                end else if (k == 8) begin
                    // Key left open; the next text beat has to finish it.
                    len = $urandom_range(1, 6);
                    for (int i = 0; i < len; i++) begin
                        add_beat(OpKey, rand_char(10), 1'b0);
                    end
                end else begin
                    len = $urandom_range(1, 8);
                    for (int i = 0; i < len; i++) begin
                        add_beat(logic'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                 $urandom_range(0, 3) == 0);
                    end
                end
                n += len;
            end
            wait_idle();
        end

        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
